// ----- design/eeg_headset_packet_parser_macros.svh -----
// ---------------------------------------------------------------------------
// eeg headset packet parser assertion macros
// shared property wrappers, compiled out for synthesis
// ---------------------------------------------------------------------------
`ifndef EEG_HEADSET_PACKET_PARSER_MACROS_SVH
`define EEG_HEADSET_PACKET_PARSER_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define EHPP_ASSERT_IMPL(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("ehpp assertion failed");

// next-cycle implication
`define EHPP_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("ehpp assertion failed");

`else

`define EHPP_ASSERT_IMPL(lbl, ck, rn, ante, cons)
`define EHPP_ASSERT_NEXT(lbl, ck, rn, ante, cons)

`endif

`endif

// ----- design/ehpp_pkg.sv -----
// ---------------------------------------------------------------------------
// ehpp_pkg
// shared constants, codes and types of the eeg headset packet parser
// ---------------------------------------------------------------------------
package ehpp_pkg;

    localparam int MAX_PAYLOAD = 32;
    localparam int AW          = $clog2(MAX_PAYLOAD);
    localparam int IDX_W       = $clog2(MAX_PAYLOAD + 1);
    localparam int BAND_COUNT  = 8;
    localparam int BAND_W      = $clog2(BAND_COUNT);
    // length byte and three bytes per band, after the code byte
    localparam int POWER_SPAN  = 1 + 3 * BAND_COUNT;
    localparam int CHK_W       = $clog2(MAX_PAYLOAD + POWER_SPAN + 1);
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [7:0] MAX_LEN         = 8'(MAX_PAYLOAD);
    localparam logic [7:0] SYNC_BYTE       = 8'd170;
    localparam logic [7:0] SUM_BASE        = 8'd255;
    localparam logic [7:0] CODE_QUALITY    = 8'd2;
    localparam logic [7:0] CODE_ATTENTION  = 8'd4;
    localparam logic [7:0] CODE_MEDITATION = 8'd5;
    localparam logic [7:0] CODE_POWER      = 8'd131;
    localparam logic [7:0] QUALITY_RESET   = 8'd200;

    typedef enum logic [2:0] {
        STAT_IDLE      = 3'd0,
        STAT_OK        = 3'd1,
        STAT_TOO_LONG  = 3'd2,
        STAT_BAD_SUM   = 3'd3,
        STAT_PARSE_ERR = 3'd4
    } status_t;

    // one queued command from the front end
    typedef struct packed {
        logic              decode;
        status_t           status;
        logic [IDX_W-1:0]  len;
        logic [31:0]       stamp;
    } cmd_t;

    // one result transaction
    typedef struct packed {
        status_t           status;
        logic [7:0]        signal_quality;
        logic [7:0]        attention;
        logic [7:0]        meditation;
        logic              has_power;
        logic [BAND_W-1:0] band_index;
        logic [23:0]       band_power;
        logic [31:0]       packet_time;
        logic              last;
    } res_t;

endpackage

// ----- design/ehpp_ram.sv -----
// ---------------------------------------------------------------------------
// ehpp_ram
// generic single write port, single read port ram with registered read
// ---------------------------------------------------------------------------
module ehpp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- design/ehpp_cmd_queue.sv -----
// ---------------------------------------------------------------------------
// ehpp_cmd_queue
// short command queue between the front end and the decode back end
// ---------------------------------------------------------------------------
module ehpp_cmd_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  ehpp_pkg::cmd_t cmd_in,
    output logic           full,
    input  logic           pop,
    output ehpp_pkg::cmd_t cmd_out,
    output logic           empty
);
    import ehpp_pkg::*;

    cmd_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wptr_reg, wptr_next;
    logic [QPTR_W-1:0] rptr_reg, rptr_next;
    logic [QPTR_W:0]   cnt_reg, cnt_next;
    logic              do_push, do_pop;

    assign full    = (cnt_reg == (QPTR_W + 1)'(QUEUE_DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign cmd_out = slot_reg[rptr_reg];

    always_comb
    begin
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        cnt_next  = cnt_reg;
        if (do_push)
        begin
            wptr_next = (wptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rptr_next = (rptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wptr_reg] <= cmd_in;
        end
    end

endmodule

// ----- design/ehpp_front.sv -----
// ---------------------------------------------------------------------------
// ehpp_front
// byte framing: sync detection, length check, payload capture, checksum
// ---------------------------------------------------------------------------
`include "eeg_headset_packet_parser_macros.svh"

module ehpp_front (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    output logic                   full,
    input  logic [7:0]             data_byte,
    input  logic [31:0]            timestamp,
    output logic                   q_push,
    output ehpp_pkg::cmd_t         q_cmd,
    input  logic                   q_full,
    output logic                   ram_we,
    output logic [ehpp_pkg::AW-1:0] ram_waddr,
    output logic [7:0]             ram_wdata,
    input  logic                   decode_done
);
    import ehpp_pkg::*;

    logic       in_pkt_reg, in_pkt_next;
    logic [7:0] pos_reg, pos_next;
    logic [7:0] len_reg, len_next;
    logic [7:0] sum_reg, sum_next;
    logic [7:0] prev_reg, prev_next;
    logic       wait_reg, wait_next;
    logic       accept;
    logic       dec;
    status_t    st;

    // payload store must not change while the back end walks it
    assign full   = wait_reg || q_full;
    assign accept = push && !full;

    always_comb
    begin
        in_pkt_next = in_pkt_reg;
        pos_next    = pos_reg;
        len_next    = len_reg;
        sum_next    = sum_reg;
        prev_next   = prev_reg;
        st          = STAT_IDLE;
        dec         = 1'b0;
        ram_we      = 1'b0;
        if (accept)
        begin
            if (in_pkt_reg)
            begin
                if (pos_reg == '0)
                begin
                    len_next = data_byte;
                    if (data_byte > MAX_LEN)
                    begin
                        st          = STAT_TOO_LONG;
                        in_pkt_next = 1'b0;
                    end
                end
                else if (pos_reg <= len_reg)
                begin
                    ram_we   = 1'b1;
                    sum_next = sum_reg + data_byte;
                end
                else
                begin
                    if (data_byte == (SUM_BASE - sum_reg))
                    begin
                        dec = 1'b1;
                    end
                    else
                    begin
                        st = STAT_BAD_SUM;
                    end
                    in_pkt_next = 1'b0;
                end
                pos_next = pos_reg + 8'd1;
            end
            if (data_byte == SYNC_BYTE && prev_reg == SYNC_BYTE && !in_pkt_next)
            begin
                in_pkt_next = 1'b1;
                pos_next    = '0;
                len_next    = '0;
                sum_next    = '0;
            end
            prev_next = data_byte;
        end
    end

    always_comb
    begin
        wait_next = wait_reg;
        if (decode_done)
        begin
            wait_next = 1'b0;
        end
        if (accept && dec)
        begin
            wait_next = 1'b1;
        end
    end

    assign ram_waddr    = AW'(pos_reg - 8'd1);
    assign ram_wdata    = data_byte;
    assign q_push       = accept;
    assign q_cmd.decode = dec;
    assign q_cmd.status = st;
    assign q_cmd.len    = IDX_W'(len_reg);
    assign q_cmd.stamp  = timestamp;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_pkt_reg <= 1'b0;
            pos_reg    <= '0;
            len_reg    <= '0;
            sum_reg    <= '0;
            prev_reg   <= '0;
            wait_reg   <= 1'b0;
        end
        else
        begin
            in_pkt_reg <= in_pkt_next;
            pos_reg    <= pos_next;
            len_reg    <= len_next;
            sum_reg    <= sum_next;
            prev_reg   <= prev_next;
            wait_reg   <= wait_next;
        end
    end

    `EHPP_ASSERT_IMPL(a_no_write_in_decode, clk, rst_n, ram_we, !wait_reg)
    `EHPP_ASSERT_NEXT(a_decode_holds_input, clk, rst_n, accept && dec, wait_reg && full)
    `EHPP_ASSERT_IMPL(a_write_inside_len, clk, rst_n, ram_we, in_pkt_reg && (len_reg <= MAX_LEN))

endmodule

// ----- design/ehpp_back.sv -----
// ---------------------------------------------------------------------------
// ehpp_back
// payload walk, value registers, band powers and result emission
// ---------------------------------------------------------------------------
`include "eeg_headset_packet_parser_macros.svh"

module ehpp_back (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    q_empty,
    input  ehpp_pkg::cmd_t          q_cmd,
    output logic                    q_pop,
    output logic                    ram_re,
    output logic [ehpp_pkg::AW-1:0] ram_raddr,
    input  logic [7:0]              ram_rdata,
    output logic                    decode_done,
    input  logic                    pop,
    output logic                    empty,
    output ehpp_pkg::res_t          out_res
);
    import ehpp_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_RUN, S_EMIT, S_ERR} state_t;
    typedef enum logic [1:0] {C_CODE, C_VAL, C_PLEN, C_PWR} walk_t;

    state_t            state_reg, state_next;
    walk_t             walk_reg, walk_next;
    logic [7:0]        sel_reg, sel_next;
    logic [IDX_W-1:0]  len_reg, len_next;
    logic [IDX_W-1:0]  iss_reg, iss_next;
    logic [IDX_W-1:0]  cidx_reg, cidx_next;
    logic              dv_reg, dv_next;
    logic [BAND_W-1:0] band_reg, band_next;
    logic [1:0]        sub_reg, sub_next;
    logic [15:0]       acc_reg, acc_next;
    logic [BAND_W-1:0] emit_reg, emit_next;
    logic [7:0]        qual_reg, qual_next;
    logic [7:0]        att_reg, att_next;
    logic [7:0]        med_reg, med_next;
    logic              pseen_reg, pseen_next;
    logic [23:0]       bands_reg [BAND_COUNT];
    logic [23:0]       bands_next [BAND_COUNT];
    logic [31:0]       time_reg, time_next;
    logic              out_valid_reg, out_valid_next;
    res_t              out_res_reg, out_res_next;
    logic              slot_free;
    logic [7:0]        d;

    assign slot_free = !out_valid_reg || pop;
    assign d         = ram_rdata;
    assign ram_re    = (state_reg == S_RUN) && (iss_reg < len_reg);
    assign ram_raddr = AW'(iss_reg);
    assign empty     = !out_valid_reg;
    assign out_res   = out_res_reg;

    always_comb
    begin
        state_next     = state_reg;
        walk_next      = walk_reg;
        sel_next       = sel_reg;
        len_next       = len_reg;
        iss_next       = iss_reg;
        cidx_next      = cidx_reg;
        dv_next        = ram_re;
        band_next      = band_reg;
        sub_next       = sub_reg;
        acc_next       = acc_reg;
        emit_next      = emit_reg;
        qual_next      = qual_reg;
        att_next       = att_reg;
        med_next       = med_reg;
        pseen_next     = pseen_reg;
        bands_next     = bands_reg;
        time_next      = time_reg;
        out_valid_next = out_valid_reg && !pop;
        out_res_next   = out_res_reg;
        q_pop          = 1'b0;
        decode_done    = 1'b0;

        // common result fields
        out_res_next.signal_quality = out_res_reg.signal_quality;

        if (ram_re)
        begin
            iss_next = iss_reg + 1'b1;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (!q_empty)
                begin
                    if (q_cmd.decode)
                    begin
                        q_pop      = 1'b1;
                        state_next = S_RUN;
                        walk_next  = C_CODE;
                        len_next   = q_cmd.len;
                        iss_next   = '0;
                        cidx_next  = '0;
                        time_next  = q_cmd.stamp;
                        pseen_next = 1'b0;
                        for (int b = 0; b < BAND_COUNT; b++)
                        begin
                            bands_next[b] = '0;
                        end
                    end
                    else if (slot_free)
                    begin
                        q_pop                       = 1'b1;
                        out_valid_next              = 1'b1;
                        out_res_next.status         = q_cmd.status;
                        out_res_next.signal_quality = qual_reg;
                        out_res_next.attention      = att_reg;
                        out_res_next.meditation     = med_reg;
                        out_res_next.has_power      = pseen_reg;
                        out_res_next.band_index     = '0;
                        out_res_next.band_power     = '0;
                        out_res_next.packet_time    = time_reg;
                        out_res_next.last           = 1'b1;
                    end
                end
            end

            S_RUN:
            begin
                if (walk_reg == C_CODE && cidx_reg == len_reg)
                begin
                    state_next = S_EMIT;
                    emit_next  = '0;
                end
                else if (dv_reg)
                begin
                    cidx_next = cidx_reg + 1'b1;
                    unique case (walk_reg)
                        C_CODE:
                        begin
                            if (d == CODE_QUALITY || d == CODE_ATTENTION ||
                                d == CODE_MEDITATION)
                            begin
                                if (CHK_W'(cidx_reg) + CHK_W'(1) >= CHK_W'(len_reg))
                                begin
                                    state_next = S_ERR;
                                end
                                else
                                begin
                                    sel_next  = d;
                                    walk_next = C_VAL;
                                end
                            end
                            else if (d == CODE_POWER)
                            begin
                                if (CHK_W'(cidx_reg) + CHK_W'(POWER_SPAN) >=
                                    CHK_W'(len_reg))
                                begin
                                    state_next = S_ERR;
                                end
                                else
                                begin
                                    pseen_next = 1'b1;
                                    walk_next  = C_PLEN;
                                end
                            end
                            else
                            begin
                                state_next = S_ERR;
                            end
                        end
                        C_VAL:
                        begin
                            priority if (sel_reg == CODE_QUALITY)
                            begin
                                qual_next = d;
                            end
                            else if (sel_reg == CODE_ATTENTION)
                            begin
                                att_next = d;
                            end
                            else
                            begin
                                med_next = d;
                            end
                            walk_next = C_CODE;
                        end
                        C_PLEN:
                        begin
                            // band length byte is skipped
                            walk_next = C_PWR;
                            band_next = '0;
                            sub_next  = '0;
                        end
                        C_PWR:
                        begin
                            if (sub_reg == 2'd2)
                            begin
                                bands_next[band_reg] = {acc_reg, d};
                                sub_next             = '0;
                                band_next            = band_reg + 1'b1;
                                if (band_reg == BAND_W'(BAND_COUNT - 1))
                                begin
                                    walk_next = C_CODE;
                                end
                            end
                            else
                            begin
                                acc_next = {acc_reg[7:0], d};
                                sub_next = sub_reg + 1'b1;
                            end
                        end
                    endcase
                end
            end

            S_EMIT:
            begin
                if (slot_free)
                begin
                    out_valid_next              = 1'b1;
                    out_res_next.status         = STAT_OK;
                    out_res_next.signal_quality = qual_reg;
                    out_res_next.attention      = att_reg;
                    out_res_next.meditation     = med_reg;
                    out_res_next.has_power      = pseen_reg;
                    out_res_next.band_index     = emit_reg;
                    out_res_next.band_power     = bands_reg[emit_reg];
                    out_res_next.packet_time    = time_reg;
                    out_res_next.last           = (emit_reg == BAND_W'(BAND_COUNT - 1));
                    emit_next                   = emit_reg + 1'b1;
                    if (emit_reg == BAND_W'(BAND_COUNT - 1))
                    begin
                        state_next  = S_IDLE;
                        decode_done = 1'b1;
                    end
                end
            end

            S_ERR:
            begin
                if (slot_free)
                begin
                    out_valid_next              = 1'b1;
                    out_res_next.status         = STAT_PARSE_ERR;
                    out_res_next.signal_quality = qual_reg;
                    out_res_next.attention      = att_reg;
                    out_res_next.meditation     = med_reg;
                    out_res_next.has_power      = pseen_reg;
                    out_res_next.band_index     = '0;
                    out_res_next.band_power     = '0;
                    out_res_next.packet_time    = time_reg;
                    out_res_next.last           = 1'b1;
                    state_next                  = S_IDLE;
                    decode_done                 = 1'b1;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            walk_reg      <= C_CODE;
            sel_reg       <= '0;
            len_reg       <= '0;
            iss_reg       <= '0;
            cidx_reg      <= '0;
            dv_reg        <= 1'b0;
            band_reg      <= '0;
            sub_reg       <= '0;
            acc_reg       <= '0;
            emit_reg      <= '0;
            qual_reg      <= QUALITY_RESET;
            att_reg       <= '0;
            med_reg       <= '0;
            pseen_reg     <= 1'b0;
            for (int b = 0; b < BAND_COUNT; b++)
            begin
                bands_reg[b] <= '0;
            end
            time_reg      <= '0;
            out_valid_reg <= 1'b0;
            out_res_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            walk_reg      <= walk_next;
            sel_reg       <= sel_next;
            len_reg       <= len_next;
            iss_reg       <= iss_next;
            cidx_reg      <= cidx_next;
            dv_reg        <= dv_next;
            band_reg      <= band_next;
            sub_reg       <= sub_next;
            acc_reg       <= acc_next;
            emit_reg      <= emit_next;
            qual_reg      <= qual_next;
            att_reg       <= att_next;
            med_reg       <= med_next;
            pseen_reg     <= pseen_next;
            bands_reg     <= bands_next;
            time_reg      <= time_next;
            out_valid_reg <= out_valid_next;
            out_res_reg   <= out_res_next;
        end
    end

    `EHPP_ASSERT_IMPL(a_data_inside_len, clk, rst_n, (state_reg == S_RUN) && dv_reg, cidx_reg < len_reg)
    `EHPP_ASSERT_IMPL(a_issue_bound, clk, rst_n, state_reg == S_RUN, iss_reg <= len_reg)
    `EHPP_ASSERT_IMPL(a_no_pop_busy, clk, rst_n, state_reg != S_IDLE, !q_pop)
    `EHPP_ASSERT_NEXT(a_done_to_idle, clk, rst_n, decode_done, (state_reg == S_IDLE) && out_valid_reg)

endmodule

// ----- design/eeg_headset_packet_parser.sv -----
// ---------------------------------------------------------------------------
// eeg_headset_packet_parser
// serial packet parser for an eeg headset: framing, checksum, payload decode
// ---------------------------------------------------------------------------
// results: one per byte, one per band for a good packet; registered output
// throughput: one byte per cycle while full is low; a good checksum byte
//   holds full through the payload walk on the ram read port and its results
// reset: asynchronous, clears framing and queues, signal quality 200,
//   attention, meditation, band powers and packet time zero
// ---------------------------------------------------------------------------
module eeg_headset_packet_parser (
    input  logic        clk,
    input  logic        rst_n,
    // input queue side
    input  logic        push,
    output logic        full,
    input  logic [7:0]  data_byte,
    input  logic [31:0] timestamp,
    // result queue side
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  status,
    output logic [7:0]  signal_quality,
    output logic [7:0]  attention,
    output logic [7:0]  meditation,
    output logic        has_power,
    output logic [2:0]  band_index,
    output logic [23:0] band_power,
    output logic [31:0] packet_time,
    output logic        last
);
    import ehpp_pkg::*;

    // front end to command queue
    logic          fq_push;
    cmd_t          fq_cmd;
    logic          fq_full;
    // command queue to back end
    cmd_t          bq_cmd;
    logic          bq_pop;
    logic          bq_empty;
    // payload store ports
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [7:0]    ram_wdata;
    logic          ram_re;
    logic [AW-1:0] ram_raddr;
    logic [7:0]    ram_rdata;
    // back end status
    logic          decode_done;
    res_t          res;

    // framing front end: one byte per transaction, raises full during a decode
    ehpp_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .data_byte   (data_byte),
        .timestamp   (timestamp),
        .q_push      (fq_push),
        .q_cmd       (fq_cmd),
        .q_full      (fq_full),
        .ram_we      (ram_we),
        .ram_waddr   (ram_waddr),
        .ram_wdata   (ram_wdata),
        .decode_done (decode_done)
    );

    // payload bytes of the packet in flight
    ehpp_ram #(
        .WIDTH (8),
        .DEPTH (MAX_PAYLOAD)
    ) u_payload_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // decouples byte intake from result emission
    ehpp_cmd_queue u_cmd_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (fq_push),
        .cmd_in  (fq_cmd),
        .full    (fq_full),
        .pop     (bq_pop),
        .cmd_out (bq_cmd),
        .empty   (bq_empty)
    );

    // payload walk and output register
    ehpp_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_empty     (bq_empty),
        .q_cmd       (bq_cmd),
        .q_pop       (bq_pop),
        .ram_re      (ram_re),
        .ram_raddr   (ram_raddr),
        .ram_rdata   (ram_rdata),
        .decode_done (decode_done),
        .pop         (pop),
        .empty       (empty),
        .out_res     (res)
    );

    // result fields onto their own ports
    assign status         = res.status;
    assign signal_quality = res.signal_quality;
    assign attention      = res.attention;
    assign meditation     = res.meditation;
    assign has_power      = res.has_power;
    assign band_index     = res.band_index;
    assign band_power     = res.band_power;
    assign packet_time    = res.packet_time;
    assign last           = res.last;

endmodule

// ----- tb/eeg_headset_packet_parser_checker.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// eeg headset packet parser checker
// watches the byte and result channels, tracks the framing and decode state
// of the parser, and compares every result transaction in order
// ---------------------------------------------------------------------------
module eeg_headset_packet_parser_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  logic        full,
    input  logic [7:0]  data_byte,
    input  logic [31:0] timestamp,
    input  logic        empty,
    input  logic        pop,
    input  logic [2:0]  status,
    input  logic [7:0]  signal_quality,
    input  logic [7:0]  attention,
    input  logic [7:0]  meditation,
    input  logic        has_power,
    input  logic [2:0]  band_index,
    input  logic [23:0] band_power,
    input  logic [31:0] packet_time,
    input  logic        last,
    output int          failures,
    output int          outstanding
);
    import ehpp_pkg::*;

    // framing state
    logic        framing;
    logic [7:0]  position;
    logic [7:0]  length_seen;
    logic [7:0]  sum_acc;
    logic [7:0]  prior_byte;
    logic [7:0]  store [MAX_PAYLOAD];

    // decoded values
    logic [7:0]  quality_now;
    logic [7:0]  attention_now;
    logic [7:0]  meditation_now;
    logic [23:0] bands [BAND_COUNT];
    logic        bands_valid;
    logic [31:0] stamp;

    res_t        results_due [$];

    // walk the payload of a packet whose checksum matched
    function automatic status_t decode_packet();
        int         n;
        int         i;
        int         b;
        int         base;
        logic [7:0] code;
        n = int'(length_seen);
        i = 0;
        bands_valid = 1'b0;
        for (b = 0; b < BAND_COUNT; b++)
            bands[b] = '0;
        while (i < n)
        begin
            code = store[i];
            if (code == CODE_QUALITY || code == CODE_ATTENTION || code == CODE_MEDITATION)
            begin
                if (i + 1 >= n)
                    return STAT_PARSE_ERR;
                case (code)
                    CODE_QUALITY:   quality_now = store[i + 1];
                    CODE_ATTENTION: attention_now = store[i + 1];
                    default:        meditation_now = store[i + 1];
                endcase
                i += 2;
            end
            else if (code == CODE_POWER)
            begin
                if (i + 1 + 3 * BAND_COUNT >= n)
                    return STAT_PARSE_ERR;
                for (b = 0; b < BAND_COUNT; b++)
                begin
                    base = i + 2 + 3 * b;
                    bands[b] = {store[base], store[base + 1], store[base + 2]};
                end
                bands_valid = 1'b1;
                i += 2 + 3 * BAND_COUNT;
            end
            else
                return STAT_PARSE_ERR;
        end
        return STAT_OK;
    endfunction

    task automatic track_byte(input logic [7:0] b, input logic [31:0] ts);
        status_t st;
        res_t    r;
        int      k;
        st = STAT_IDLE;
        if (framing)
        begin
            if (position == 8'd0)
            begin
                length_seen = b;
                if (b > MAX_LEN)
                begin
                    st = STAT_TOO_LONG;
                    framing = 1'b0;
                end
            end
            else if (position <= length_seen)
            begin
                store[int'(position) - 1] = b;
                sum_acc = sum_acc + b;
            end
            else
            begin
                if (b == 8'(SUM_BASE - sum_acc))
                begin
                    stamp = ts;
                    st = decode_packet();
                end
                else
                    st = STAT_BAD_SUM;
                framing = 1'b0;
            end
            position = position + 8'd1;
        end
        // a sync pair can start a packet on any byte seen outside one
        if (b == SYNC_BYTE && prior_byte == SYNC_BYTE && !framing)
        begin
            framing = 1'b1;
            position = '0;
            length_seen = '0;
            sum_acc = '0;
        end
        prior_byte = b;

        r.status = st;
        r.signal_quality = quality_now;
        r.attention = attention_now;
        r.meditation = meditation_now;
        r.has_power = bands_valid;
        r.packet_time = stamp;
        if (st == STAT_OK)
        begin
            for (k = 0; k < BAND_COUNT; k++)
            begin
                r.band_index = BAND_W'(k);
                r.band_power = bands[k];
                r.last = (k == BAND_COUNT - 1);
                results_due = {results_due, r};
            end
        end
        else
        begin
            r.band_index = '0;
            r.band_power = '0;
            r.last = 1'b1;
            results_due = {results_due, r};
        end
    endtask

    task automatic check_field(input string name, input longint unsigned want,
                               input longint unsigned got);
        if (want != got)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            failures++;
        end
    endtask

    task automatic check_result();
        res_t e;
        if (results_due.size() == 0)
        begin
            $error("result transaction with no expected result pending");
            failures++;
        end
        else
        begin
            e = results_due.pop_front();
            check_field("status", e.status, status);
            check_field("signal_quality", e.signal_quality, signal_quality);
            check_field("attention", e.attention, attention);
            check_field("meditation", e.meditation, meditation);
            check_field("has_power", e.has_power, has_power);
            check_field("band_index", e.band_index, band_index);
            check_field("band_power", e.band_power, band_power);
            check_field("packet_time", e.packet_time, packet_time);
            check_field("last", e.last, last);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        int k;
        if (!rst_n)
        begin
            framing = 1'b0;
            position = '0;
            length_seen = '0;
            sum_acc = '0;
            prior_byte = '0;
            for (k = 0; k < MAX_PAYLOAD; k++)
                store[k] = '0;
            quality_now = QUALITY_RESET;
            attention_now = '0;
            meditation_now = '0;
            for (k = 0; k < BAND_COUNT; k++)
                bands[k] = '0;
            bands_valid = 1'b0;
            stamp = '0;
            results_due.delete();
            failures = 0;
        end
        else
        begin
            // results for a byte come later than its transaction, so order here is free
            if (pop && !empty)
                check_result();
            if (push && !full)
                track_byte(data_byte, timestamp);
        end
        outstanding = results_due.size();
    end

endmodule

// ----- tb/tb_eeg_headset_packet_parser.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// eeg headset packet parser testbench
// drives framed and broken serial packets with random gaps, pops results
// with random stalls, and reports the checker's verdict
// ---------------------------------------------------------------------------
module tb_eeg_headset_packet_parser;
    import ehpp_pkg::*;

    localparam int HALF_PERIOD    = 6;
    localparam int RESET_CYCLES   = 8;
    localparam int RANDOM_BYTES   = 220;
    // worst quiet stretch is a long sender gap, a payload walk and a long pop stall
    localparam int WATCHDOG_LIMIT = 2000;
    // slack after the last expected result is in
    localparam int DRAIN_CYCLES   = 16;

    typedef logic [7:0] bytes_t [$];
    typedef enum {TS_RANDOM, TS_ZERO, TS_ONES} ts_mode_t;

    logic        clk;
    logic        rst_n;
    logic        push;
    logic        full;
    logic [7:0]  data_byte;
    logic [31:0] timestamp;
    logic        empty;
    logic        pop;
    logic [2:0]  status;
    logic [7:0]  signal_quality;
    logic [7:0]  attention;
    logic [7:0]  meditation;
    logic        has_power;
    logic [2:0]  band_index;
    logic [23:0] band_power;
    logic [31:0] packet_time;
    logic        last;

    int          failures;
    int          outstanding;
    int          quiet_cycles;
    // set per packet: no sender gaps at all
    bit          steady;

    eeg_headset_packet_parser uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .data_byte      (data_byte),
        .timestamp      (timestamp),
        .empty          (empty),
        .pop            (pop),
        .status         (status),
        .signal_quality (signal_quality),
        .attention      (attention),
        .meditation     (meditation),
        .has_power      (has_power),
        .band_index     (band_index),
        .band_power     (band_power),
        .packet_time    (packet_time),
        .last           (last)
    );

    eeg_headset_packet_parser_checker u_chk (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .data_byte      (data_byte),
        .timestamp      (timestamp),
        .empty          (empty),
        .pop            (pop),
        .status         (status),
        .signal_quality (signal_quality),
        .attention      (attention),
        .meditation     (meditation),
        .has_power      (has_power),
        .band_index     (band_index),
        .band_power     (band_power),
        .packet_time    (packet_time),
        .last           (last),
        .failures       (failures),
        .outstanding    (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #HALF_PERIOD clk = ~clk;
    end

    // gap lengths: mostly none or short, now and then a long one
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] value_code();
        case ($urandom_range(0, 2))
            0:       return CODE_QUALITY;
            1:       return CODE_ATTENTION;
            default: return CODE_MEDITATION;
        endcase
    endfunction

    // well-formed payload: value codes and band power blocks that fit the maximum
    function automatic bytes_t good_payload();
        bytes_t p;
        int     n;
        forever
        begin
            if ($urandom_range(0, 2) == 0)
            begin
                if (p.size() + 2 + 3 * BAND_COUNT > MAX_PAYLOAD)
                    break;
                p = {p, CODE_POWER};
                // band length byte, read past by the parser
                p = {p, 8'($urandom_range(0, 255))};
                for (n = 0; n < 3 * BAND_COUNT; n++)
                    p = {p, 8'($urandom_range(0, 255))};
            end
            else
            begin
                if (p.size() + 2 > MAX_PAYLOAD)
                    break;
                p = {p, value_code()};
                p = {p, 8'($urandom_range(0, 255))};
            end
            if ($urandom_range(0, 3) == 0)
                break;
        end
        return p;
    endfunction

    // sync pair, length, payload and checksum, optionally with a wrong checksum
    function automatic bytes_t frame(input bytes_t body, input bit bad_sum);
        bytes_t     s;
        logic [7:0] acc;
        logic [7:0] flip;
        acc = '0;
        foreach (body[i])
            acc = acc + body[i];
        flip = bad_sum ? 8'($urandom_range(1, 255)) : 8'd0;
        s = {SYNC_BYTE, SYNC_BYTE, 8'(body.size())};
        s = {s, body};
        s = {s, 8'(SUM_BASE - acc) ^ flip};
        return s;
    endfunction

    // one byte transaction, with a random gap ahead of it unless the packet is steady
    task automatic send_byte(input logic [7:0] b, input logic [31:0] ts);
        int gap;
        gap = steady ? 0 : idle_len();
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push      <= 1'b1;
        data_byte <= b;
        timestamp <= ts;
        @(posedge clk);
        while (full)
            @(posedge clk);
    endtask

    task automatic send_stream(input bytes_t s, input ts_mode_t mode);
        foreach (s[i])
        begin
            case (mode)
                TS_ZERO: send_byte(s[i], 32'h0000_0000);
                TS_ONES: send_byte(s[i], 32'hFFFF_FFFF);
                default: send_byte(s[i], $urandom());
            endcase
        end
    endtask

    // stray bytes between packets, sync bytes among them now and then
    task automatic send_noise(input int n);
        repeat (n)
            send_byte(($urandom_range(0, 3) == 0) ? SYNC_BYTE : 8'($urandom_range(0, 255)),
                      $urandom());
    endtask

    // broken tail: unknown code, value code with no value, or short band block
    function automatic bytes_t broken_payload();
        bytes_t     body;
        bytes_t     tail;
        logic [7:0] c;
        body = good_payload();
        case ($urandom_range(0, 2))
            0:
            begin
                do
                    c = 8'($urandom_range(0, 255));
                while (c == CODE_QUALITY || c == CODE_ATTENTION ||
                       c == CODE_MEDITATION || c == CODE_POWER);
                tail = {tail, c};
            end
            1: tail = {tail, value_code()};
            default:
            begin
                tail = {tail, CODE_POWER};
                repeat ($urandom_range(0, 3 * BAND_COUNT))
                    tail = {tail, 8'($urandom_range(0, 255))};
            end
        endcase
        if (body.size() + tail.size() > MAX_PAYLOAD)
            body.delete();
        body = {body, tail};
        return body;
    endfunction

    // ---------------------------------------------------------------------
    // stimulus
    // ---------------------------------------------------------------------
    initial
    begin
        bytes_t s;
        bytes_t body;
        int     sent;
        int     r;
        int     n;

        rst_n     <= 1'b0;
        push      <= 1'b0;
        data_byte <= '0;
        timestamp <= '0;
        steady    = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: good packet with quality 0 and attention 255, all-ones time
        body = {CODE_QUALITY, 8'h00, CODE_ATTENTION, 8'hFF};
        send_stream(frame(body, 1'b0), TS_ONES);

        // directed: length byte is a sync byte, too long, and it pairs with the one
        // before to open a new packet; that one is empty and good, zero time
        s = {SYNC_BYTE, SYNC_BYTE, SYNC_BYTE, 8'h00, 8'hFF};
        send_stream(s, TS_ZERO);

        // directed: checksum mismatch, meditation must not change
        body = {CODE_MEDITATION, 8'h10};
        send_stream(frame(body, 1'b1), TS_RANDOM);

        // directed: unknown code
        body = {8'h07};
        send_stream(frame(body, 1'b0), TS_RANDOM);

        // directed: meditation decoded, then attention value runs past the payload
        body = {CODE_MEDITATION, 8'd77, CODE_ATTENTION};
        send_stream(frame(body, 1'b0), TS_RANDOM);

        // random part: mostly well-formed packets, some broken, some noise
        sent = 0;
        while (sent < RANDOM_BYTES)
        begin
            steady = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 9) < 3)
            begin
                n = $urandom_range(1, 4);
                send_noise(n);
                sent += n;
            end
            r = $urandom_range(0, 99);
            if (r < 55)
                s = frame(good_payload(), 1'b0);
            else if (r < 65)
                s = frame(good_payload(), 1'b1);
            else if (r < 80)
                s = frame(broken_payload(), 1'b0);
            else if (r < 90)
                s = {SYNC_BYTE, SYNC_BYTE, 8'($urandom_range(MAX_PAYLOAD + 1, 255))};
            else
            begin
                // arbitrary payload of any legal length with a correct checksum
                body.delete();
                n = $urandom_range(0, MAX_PAYLOAD);
                repeat (n)
                    body = {body, 8'($urandom_range(0, 255))};
                s = frame(body, 1'b0);
            end
            send_stream(s, TS_RANDOM);
            sent += s.size();
            if (r >= 80 && r < 90)
            begin
                n = $urandom_range(0, 5);
                send_noise(n);
                sent += n;
            end
        end
        push <= 1'b0;

        // drain: every expected result in, then a few quiet cycles
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (failures == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // ---------------------------------------------------------------------
    // result side: random pop stalls with bursts of continuous popping
    // ---------------------------------------------------------------------
    initial
    begin
        int n;
        pop <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                pop <= 1'b1;
                repeat ($urandom_range(20, 100)) @(posedge clk);
            end
            else
            begin
                n = idle_len();
                if (n > 0)
                begin
                    pop <= 1'b0;
                    repeat (n) @(posedge clk);
                end
                pop <= 1'b1;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
        end
    end

    // ---------------------------------------------------------------------
    // watchdog: ends the run if no transaction moves on either side for too long
    // ---------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
            quiet_cycles <= 0;
        else if ((push && !full) || (pop && !empty))
            quiet_cycles <= 0;
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

endmodule
